// ----- hdl/cfr_pkg.sv -----
// ----------------------------------------------------------------------------
// cfr_pkg: shared definitions for the clock frame replacement block
// command, status and register index codes and fixed field widths
// ----------------------------------------------------------------------------
package cfr_pkg;

    localparam int CMD_W    = 2;
    localparam int PID_W    = 16;
    localparam int TGT_W    = 6;
    localparam int STATUS_W = 3;
    localparam int FRAME_W  = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    typedef logic [CMD_W-1:0]    t_cmd;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_cmd CMD_ALLOCATE = 2'd0;
    localparam t_cmd CMD_RELEASE  = 2'd1;
    localparam t_cmd CMD_FAULT    = 2'd2;
    localparam t_cmd CMD_MARK     = 2'd3;

    localparam t_status ST_DONE       = 3'd0;
    localparam t_status ST_FREE_GIVEN = 3'd1;
    localparam t_status ST_REPLACED   = 3'd2;
    localparam t_status ST_NO_FRAMES  = 3'd3;
    localparam t_status ST_NO_GROUP   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_FRAMES_PER_PROC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPL_MODE       = 2'd2;

endpackage

// ----- hdl/clock_frame_replacement.sv -----
// ----------------------------------------------------------------------------
// clock_frame_replacement: physical frame manager with clock replacement
// per-process frame groups, allocate / release / page fault / mark written,
// victim choice by clock or enhanced clock under a small sequencer
// ----------------------------------------------------------------------------
//
//  channel   signals                                        direction
//  input     i_in_valid / o_in_ready, command, pid, target  in
//  result    o_out_valid / i_out_ready, status, frame, wb   out
//  config    i_cfg_we, i_cfg_idx, i_cfg_wdata               in, no wait
//
//  one transaction in, one transaction out; the block takes a new
//  transaction only from idle, so items are handled one at a time
//  a fault searches and counts the group frames, then reads the hand, scans
//  one frame per cycle and loads the victim when no free frame is found
//  reset: synchronous, flag vectors set at once (free flags to one, the rest to zero), no clearing pass
//  result stalls hold the finished result in the done state
module clock_frame_replacement #(
    parameter int NUM_FRAMES       = 64,
    parameter int MAX_GROUP_FRAMES = 16,
    parameter int ID_BITS          = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [cfr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cfr_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [cfr_pkg::CMD_W-1:0]  i_command,
    input  logic [cfr_pkg::PID_W-1:0]  i_process_id,
    input  logic [cfr_pkg::TGT_W-1:0]  i_target_frame,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [cfr_pkg::STATUS_W-1:0] o_status,
    output logic [cfr_pkg::FRAME_W-1:0]  o_frame,
    output logic                       o_needs_writeback
);
    import cfr_pkg::*;

    // widths
    localparam int FW = $clog2(NUM_FRAMES);           // frame index
    localparam int PW = FW + 1;                        // pointer, holds NUM_FRAMES
    localparam int GW = $clog2(MAX_GROUP_FRAMES + 1);  // group offset / size
    localparam int SW = ((PW > GW) ? PW : GW) + 1;     // sum width
    localparam int IW = (ID_BITS < PID_W) ? ID_BITS : PID_W;
    localparam int TW = ((FW > TGT_W) ? FW : TGT_W) + 1;

    // sequencer codes
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ASCAN = 4'd1;   // look for an unowned aligned group
    localparam logic [3:0] S_AFILL = 4'd2;   // claim the group, one frame a cycle
    localparam logic [3:0] S_RRD   = 4'd3;   // release: owner read
    localparam logic [3:0] S_RCHK  = 4'd4;   // release: compare and free
    localparam logic [3:0] S_FRD   = 4'd5;   // fault: owner read (find, then count)
    localparam logic [3:0] S_FCHK  = 4'd6;   // fault: owner compare
    localparam logic [3:0] S_FFREE = 4'd7;   // fault: first free frame of group
    localparam logic [3:0] S_HRD   = 4'd8;   // hand read
    localparam logic [3:0] S_HCHK  = 4'd9;   // hand loaded
    localparam logic [3:0] S_VSCAN = 4'd10;  // clock passes
    localparam logic [3:0] S_VDONE = 4'd11;  // victim loaded, hand moved
    localparam logic [3:0] S_MARK  = 4'd12;
    localparam logic [3:0] S_DONE  = 4'd13;  // result waits for the output slot

    // configuration
    logic [4:0] r_fpp;
    logic [6:0] r_fc;
    logic       r_mode;

    // per-frame flags
    logic [NUM_FRAMES-1:0] r_owned, r_free, r_use, r_mod, r_hvld;

    // owner id and hand stores, registered reads
    logic [IW-1:0] r_owner_mem [NUM_FRAMES];
    logic [GW-1:0] r_hand_mem  [NUM_FRAMES];
    logic [IW-1:0] r_owner_rd;
    logic [GW-1:0] r_hand_rd;

    // sequencer
    logic [3:0]    r_state, n_state;
    logic [IW-1:0] r_pid;
    logic [TGT_W-1:0] r_tf;
    logic [PW-1:0] r_base, r_f;
    logic [GW-1:0] r_j, r_n, r_i;
    logic [1:0]    r_pass;
    logic          r_found;

    // staged and registered result
    t_status       r_res_st;
    logic [FRAME_W-1:0] r_res_fr;
    logic          r_res_wb;
    logic          r_ovld;
    t_status       r_ost;
    logic [FRAME_W-1:0] r_ofr;
    logic          r_owb;

    // derived configuration
    logic [GW-1:0] w_g;
    logic [PW-1:0] w_lim;
    logic [7:0]    w_fpp8;
    logic [11:0]   w_fc12;

    // working values
    logic [PW-1:0] w_af, w_ff;
    logic [FW-1:0] w_afi, w_ffi, w_rfi, w_basei, w_tfi;
    logic          w_alloc_fail, w_match, w_count_end, w_find_end, w_out_free;
    logic [TW-1:0] w_tf_ext, w_lim_ext;
    logic [GW-1:0] w_hand;
    logic [GW:0]   w_vnext;
    logic          w_use, w_modb, w_hit;
    logic          w_accept;

    function automatic logic [FRAME_W-1:0] f6(input logic [FW-1:0] f);
        logic [FW+FRAME_W-1:0] wide;
        wide = (FW + FRAME_W)'(f);
        return wide[FRAME_W-1:0];
    endfunction

    // group size clamped to 1..MAX_GROUP_FRAMES, frame limit to NUM_FRAMES
    always_comb begin
        w_fpp8 = {3'b000, r_fpp};
        if (r_fpp == 5'd0) begin
            w_g = GW'(1);
        end else if (w_fpp8 > 8'(MAX_GROUP_FRAMES)) begin
            w_g = GW'(MAX_GROUP_FRAMES);
        end else begin
            w_g = GW'(r_fpp);
        end
        w_fc12 = {5'b00000, r_fc};
        if (w_fc12 < 12'(NUM_FRAMES)) begin
            w_lim = PW'(r_fc);
        end else begin
            w_lim = PW'(NUM_FRAMES);
        end
    end

    assign w_af  = r_base + PW'(r_j);
    assign w_ff  = r_base + PW'(r_i);
    assign w_afi = w_af[FW-1:0];
    assign w_ffi = w_ff[FW-1:0];
    assign w_rfi = r_f[FW-1:0];
    assign w_basei = r_base[FW-1:0];

    assign w_alloc_fail = (SW'(r_base) + SW'(w_g)) > SW'(w_lim);
    assign w_match      = r_owned[w_rfi] && (r_owner_rd == r_pid);
    assign w_find_end   = !r_found && (r_f >= w_lim);
    assign w_count_end  = r_found && ((r_n >= w_g) || (r_f >= w_lim));

    assign w_tf_ext  = TW'(r_tf);
    assign w_lim_ext = TW'(w_lim);
    assign w_tfi     = w_tf_ext[FW-1:0];

    assign w_hand  = r_hvld[w_basei] ? r_hand_rd : '0;
    assign w_vnext = (GW+1)'(r_i) + (GW+1)'(1);

    // victim test for the frame under the scan
    always_comb begin
        w_use  = r_use[w_ffi];
        w_modb = r_mod[w_ffi];
        if (!r_mode) begin
            w_hit = !w_use;
        end else if (!r_pass[0]) begin
            w_hit = !w_use && !w_modb;
        end else begin
            w_hit = !w_use && w_modb;
        end
    end

    assign w_out_free = !r_ovld || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_command)
                        CMD_ALLOCATE: n_state = S_ASCAN;
                        CMD_RELEASE:  n_state = S_RRD;
                        CMD_FAULT:    n_state = S_FRD;
                        CMD_MARK:     n_state = S_MARK;
                        default:      n_state = S_IDLE;
                    endcase
                end
            end
            S_ASCAN: begin
                if (w_alloc_fail) begin
                    n_state = S_DONE;
                end else if (!r_owned[w_afi] && (r_j == w_g - GW'(1))) begin
                    n_state = S_AFILL;
                end
            end
            S_AFILL: if (r_j == w_g - GW'(1)) n_state = S_DONE;
            S_RRD:   n_state = S_RCHK;
            S_RCHK:  n_state = (r_f == PW'(NUM_FRAMES - 1)) ? S_DONE : S_RRD;
            S_FRD: begin
                if (w_find_end) n_state = S_DONE;
                else if (w_count_end) n_state = S_FFREE;
                else n_state = S_FCHK;
            end
            S_FCHK: begin
                if (r_found && !w_match) n_state = S_FFREE;
                else n_state = S_FRD;
            end
            S_FFREE: begin
                if (r_free[w_ffi]) n_state = S_DONE;
                else if (r_i == r_n - GW'(1)) n_state = S_HRD;
            end
            S_HRD:   n_state = S_HCHK;
            S_HCHK:  n_state = S_VSCAN;
            S_VSCAN: begin
                if (r_i >= r_n) begin
                    if (r_pass == 2'd3) n_state = S_VDONE;
                end else if (w_hit) begin
                    n_state = S_VDONE;
                end
            end
            S_VDONE: n_state = S_DONE;
            S_MARK:  n_state = S_DONE;
            S_DONE:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // owner and hand stores
    always_ff @(posedge i_clk) begin
        if (r_state == S_AFILL) begin
            r_owner_mem[w_afi] <= r_pid;
        end
        r_owner_rd <= r_owner_mem[w_rfi];
        if (r_state == S_VDONE) begin
            r_hand_mem[w_basei] <= (w_vnext >= (GW+1)'(r_n)) ? '0 : w_vnext[GW-1:0];
        end
        r_hand_rd <= r_hand_mem[w_basei];
    end

    // control, flags and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fpp   <= 5'd4;
            r_fc    <= 7'd64;
            r_mode  <= 1'b0;
            r_owned <= '0;
            r_free  <= '1;
            r_use   <= '0;
            r_mod   <= '0;
            r_hvld  <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_FRAMES_PER_PROC: r_fpp  <= i_cfg_wdata[4:0];
                    REG_FRAME_COUNT:     r_fc   <= i_cfg_wdata;
                    REG_REPL_MODE:       r_mode <= i_cfg_wdata[0];
                    default: ;
                endcase
            end

            // output slot: loaded from the done state, emptied on acceptance
            if ((r_state == S_DONE) && w_out_free) r_ovld <= 1'b1;
            else if (r_ovld && i_out_ready) r_ovld <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_pid    <= i_process_id[IW-1:0];
                        r_tf     <= i_target_frame;
                        r_base   <= '0;
                        r_f      <= '0;
                        r_j      <= '0;
                        r_n      <= '0;
                        r_i      <= '0;
                        r_pass   <= '0;
                        r_found  <= 1'b0;
                        r_res_st <= ST_DONE;
                        r_res_fr <= '0;
                        r_res_wb <= 1'b0;
                    end
                end
                S_ASCAN: begin
                    if (w_alloc_fail) begin
                        r_res_st <= ST_NO_GROUP;
                    end else if (r_owned[w_afi]) begin
                        r_base <= r_base + PW'(w_g);
                        r_j    <= '0;
                    end else if (r_j == w_g - GW'(1)) begin
                        r_j <= '0;
                    end else begin
                        r_j <= r_j + GW'(1);
                    end
                end
                S_AFILL: begin
                    r_owned[w_afi] <= 1'b1;
                    r_free[w_afi]  <= 1'b1;
                    r_use[w_afi]   <= 1'b0;
                    r_mod[w_afi]   <= 1'b0;
                    r_hvld[w_afi]  <= 1'b0;
                    r_j            <= r_j + GW'(1);
                    r_res_fr       <= f6(w_basei);
                end
                S_RCHK: begin
                    if (w_match) begin
                        r_owned[w_rfi] <= 1'b0;
                        r_free[w_rfi]  <= 1'b1;
                        r_use[w_rfi]   <= 1'b0;
                        r_mod[w_rfi]   <= 1'b0;
                        r_hvld[w_rfi]  <= 1'b0;
                    end
                    r_f <= r_f + PW'(1);
                end
                S_FRD: begin
                    if (w_find_end) r_res_st <= ST_NO_FRAMES;
                end
                S_FCHK: begin
                    if (!r_found) begin
                        if (w_match) begin
                            r_found <= 1'b1;
                            r_base  <= r_f;
                            r_n     <= GW'(1);
                        end
                        r_f <= r_f + PW'(1);
                    end else if (w_match) begin
                        r_n <= r_n + GW'(1);
                        r_f <= r_f + PW'(1);
                    end
                end
                S_FFREE: begin
                    if (r_free[w_ffi]) begin
                        r_free[w_ffi] <= 1'b0;
                        r_use[w_ffi]  <= 1'b1;
                        r_mod[w_ffi]  <= 1'b0;
                        r_res_st      <= ST_FREE_GIVEN;
                        r_res_fr      <= f6(w_ffi);
                    end else begin
                        r_i <= r_i + GW'(1);
                    end
                end
                S_HCHK: begin
                    r_i    <= w_hand;
                    r_pass <= '0;
                end
                S_VSCAN: begin
                    if (r_i >= r_n) begin
                        // pass over without a victim: restart at the group start
                        r_i <= '0;
                        if (r_pass != 2'd3) r_pass <= r_pass + 2'd1;
                    end else if (!w_hit) begin
                        if (!r_mode || r_pass[0]) r_use[w_ffi] <= 1'b0;
                        r_i <= r_i + GW'(1);
                    end
                end
                S_VDONE: begin
                    r_hvld[w_basei] <= 1'b1;
                    r_res_st        <= ST_REPLACED;
                    r_res_fr        <= f6(w_ffi);
                    r_res_wb        <= r_mod[w_ffi];
                    r_free[w_ffi]   <= 1'b0;
                    r_use[w_ffi]    <= 1'b1;
                    r_mod[w_ffi]    <= 1'b0;
                end
                S_MARK: begin
                    if ((w_tf_ext < w_lim_ext) && !r_free[w_tfi]) r_mod[w_tfi] <= 1'b1;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_ost  <= r_res_st;
                        r_ofr  <= r_res_fr;
                        r_owb  <= r_res_wb;
                    end
                end
                default: ;
            endcase
        end
    end

    // when four passes over the group end with no victim, the scan picks the
    // first frame of the group; r_i is zero then, so the flow above holds
    assign o_out_valid       = r_ovld;
    assign o_status          = r_ost;
    assign o_frame           = r_ofr;
    assign o_needs_writeback = r_owb;

endmodule
